>>> rtl/kcd_pkg.sv
// kcd_pkg: shared constants for the k-core decomposition block
// field widths, opcodes, status codes and default sizes; no dependencies
`default_nettype none
package kcd_pkg;
   localparam int OP_W      = 2;
   localparam int ID_W      = 10;
   localparam int CORE_W    = 13;
   localparam int STAT_W    = 2;
   localparam int NCOUNT_W  = 11;

   localparam int DEF_MAX_NODES = 1024;
   localparam int DEF_MAX_EDGES = 4096;

   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD     = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;
   localparam logic [OP_W-1:0] OP_READ    = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD     = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTCOMP = 2'd3;
endpackage
`default_nettype wire

>>> rtl/graph_kcore_decomposition.sv
// graph_kcore_decomposition: top level of the k-core decomposition block
// depends on kcd_pkg and kcd_ram; the edge list and all working arrays live in kcd_ram instances
//
// usage: a command beat is taken when start is high and busy is low. opcodes:
// clear graph, add edge, compute cores, read core of node. every command gives
// exactly one result beat on rsp_* marked by rsp_strobe for one cycle; the
// receiver cannot stall, results are simply presented.
// latency: clear, add edge and rejected reads answer on the cycle after the
// beat and a new beat is taken every cycle; a valid read answers after the degree
// memory read and the S_RD_W state, with busy high meanwhile.
// compute runs a sequencer over the memories in the steps degree clear, degree
// count, offsets, adjacency fill, bin sort, peel setup and peel, over the active
// nodes and the stored edges; each memory has a single write port and a single
// read port. busy stays high meanwhile.
// csr_we writes node_count (0 acts as 1, above MAX_NODES as MAX_NODES) and
// invalidates computed cores. reset empties the edge list, sets node_count
// to 1 and marks cores as not computed; memories are not cleared.
`default_nettype none
module graph_kcore_decomposition #(
   parameter int MAX_NODES = kcd_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = kcd_pkg::DEF_MAX_EDGES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [kcd_pkg::OP_W-1:0]      req_opcode,
   input  wire logic [kcd_pkg::ID_W-1:0]      req_node_a,
   input  wire logic [kcd_pkg::ID_W-1:0]      req_node_b,
   output logic                               rsp_strobe,
   output logic [kcd_pkg::ID_W-1:0]           rsp_node_id,
   output logic [kcd_pkg::CORE_W-1:0]         rsp_core_number,
   output logic [kcd_pkg::STAT_W-1:0]         rsp_status,
   input  wire logic                          csr_we,
   input  wire logic [kcd_pkg::NCOUNT_W-1:0]  csr_wdata
);
   import kcd_pkg::*;

   localparam int NW   = $clog2(MAX_NODES);
   localparam int NCW  = $clog2(MAX_NODES + 1);
   localparam int EW   = $clog2(MAX_EDGES + 1);
   localparam int DW   = EW;
   localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int TAW  = $clog2(2 * MAX_EDGES);
   localparam int OW   = $clog2(2 * MAX_EDGES + 1);
   localparam int PW   = (OW > NW) ? OW : NW;
   localparam int CW   = (EW > NCW) ? EW : NCW;

   typedef enum logic [5:0] {
      S_IDLE, S_RD_W,
      S_CLR, S_DG_RD, S_DG_A, S_DG_AW, S_DG_BW,
      S_OFF_RD, S_OFF_W,
      S_ADJ_RD, S_ADJ_A, S_ADJ_AW, S_ADJ_BW,
      S_BCLR, S_BCNT_RD, S_BCNT_B, S_BCNT_W, S_BPRE_RD, S_BPRE_W,
      S_PL_RD, S_PL_B, S_PL_W, S_SH_RD, S_SH_W,
      S_PE_RD, S_PE_V, S_PE_V2, S_PE_V3, S_PE_K, S_PE_U, S_PE_DU, S_PE_PW,
      S_PE_W, S_PE_SW2, S_PE_FIN
   } state_type;

   state_type           state_ff;
   logic [CW-1:0]       cnt_ff;
   logic [OW-1:0]       k_ff, kend_ff, acc_ff;
   logic [NW-1:0]       ea_ff, eb_ff, v_ff, u_ff, w_ff, pu_ff, pw_ff;
   logic [DW-1:0]       dv_ff, du_ff, maxd_ff;
   logic [NCW-1:0]      start_ff;
   logic [EW-1:0]       edges_ff;
   logic                valid_ff;
   logic [NCOUNT_W-1:0] ncount_ff;
   logic [ID_W-1:0]     node_a_ff;
   logic                rsp_strobe_ff;
   logic [ID_W-1:0]     rsp_node_id_ff;
   logic [CORE_W-1:0]   rsp_core_ff;
   logic [STAT_W-1:0]   rsp_status_ff;

   logic e_we; logic [EAW-1:0] e_wa, e_ra; logic [2*NW-1:0] e_wd, e_rd;
   logic d_we; logic [NW-1:0]  d_wa, d_ra; logic [DW-1:0]   d_wd, d_rd;
   logic o_we; logic [NCW-1:0] o_wa, o_ra; logic [OW-1:0]   o_wd, o_rd;
   logic t_we; logic [TAW-1:0] t_wa, t_ra; logic [NW-1:0]   t_wd, t_rd;
   logic r_we; logic [NW-1:0]  r_wa, r_ra; logic [NW-1:0]   r_wd, r_rd;
   logic p_we; logic [NW-1:0]  p_wa, p_ra; logic [PW-1:0]   p_wd, p_rd;
   logic b_we; logic [EW-1:0]  b_wa, b_ra; logic [NCW-1:0]  b_wd, b_rd;

   logic [NCW-1:0] act_n;
   logic           accept, a_bad, b_bad, e_ok;
   logic [NW-1:0]  e_a, e_b;

   always_comb begin
      if (ncount_ff == '0) begin
         act_n = NCW'(1);
      end else if (32'(ncount_ff) > 32'(MAX_NODES)) begin
         act_n = NCW'(MAX_NODES);
      end else begin
         act_n = NCW'(ncount_ff);
      end
   end

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign a_bad  = 32'(req_node_a) >= 32'(act_n);
   assign b_bad  = 32'(req_node_b) >= 32'(act_n);
   assign e_a    = e_rd[2*NW-1:NW];
   assign e_b    = e_rd[NW-1:0];
   assign e_ok   = (32'(e_a) < 32'(act_n)) && (32'(e_b) < 32'(act_n)) && (e_a != e_b);

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_node_id     = rsp_node_id_ff;
   assign rsp_core_number = rsp_core_ff;
   assign rsp_status      = rsp_status_ff;

   always_comb begin
      e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
      d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
      o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
      t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
      r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
      b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_opcode == OP_ADD && !a_bad && !b_bad
                && req_node_a != req_node_b && edges_ff != EW'(MAX_EDGES)) begin
               e_we = 1'b1;
               e_wa = edges_ff[EAW-1:0];
               e_wd = {NW'(req_node_a), NW'(req_node_b)};
            end
            d_ra = NW'(req_node_a);
         end
         S_CLR: begin
            d_we = 1'b1; d_wa = cnt_ff[NW-1:0]; d_wd = '0;
         end
         S_DG_RD:  e_ra = cnt_ff[EAW-1:0];
         S_DG_A:   d_ra = e_a;
         S_DG_AW: begin
            d_we = 1'b1; d_wa = ea_ff; d_wd = d_rd + 1'b1; d_ra = eb_ff;
         end
         S_DG_BW: begin
            d_we = 1'b1; d_wa = eb_ff; d_wd = d_rd + 1'b1;
         end
         S_OFF_RD: begin
            d_ra = cnt_ff[NW-1:0];
            if (cnt_ff == CW'(act_n)) begin
               o_we = 1'b1; o_wa = act_n; o_wd = acc_ff;
            end
         end
         S_OFF_W: begin
            o_we = 1'b1; o_wa = NCW'(cnt_ff); o_wd = acc_ff;
            p_we = 1'b1; p_wa = cnt_ff[NW-1:0]; p_wd = PW'(acc_ff);
         end
         S_ADJ_RD: e_ra = cnt_ff[EAW-1:0];
         S_ADJ_A:  p_ra = e_a;
         S_ADJ_AW: begin
            t_we = 1'b1; t_wa = p_rd[TAW-1:0]; t_wd = eb_ff;
            p_we = 1'b1; p_wa = ea_ff; p_wd = p_rd + 1'b1; p_ra = eb_ff;
         end
         S_ADJ_BW: begin
            t_we = 1'b1; t_wa = p_rd[TAW-1:0]; t_wd = ea_ff;
            p_we = 1'b1; p_wa = eb_ff; p_wd = p_rd + 1'b1;
         end
         S_BCLR: begin
            b_we = 1'b1; b_wa = cnt_ff[EW-1:0]; b_wd = '0;
         end
         S_BCNT_RD: d_ra = cnt_ff[NW-1:0];
         S_BCNT_B:  b_ra = d_rd;
         S_BCNT_W: begin
            b_we = 1'b1; b_wa = du_ff; b_wd = b_rd + 1'b1;
         end
         S_BPRE_RD: b_ra = cnt_ff[EW-1:0];
         S_BPRE_W: begin
            b_we = 1'b1; b_wa = cnt_ff[EW-1:0]; b_wd = start_ff;
         end
         S_PL_RD: d_ra = cnt_ff[NW-1:0];
         S_PL_B:  b_ra = d_rd;
         S_PL_W: begin
            b_we = 1'b1; b_wa = du_ff; b_wd = b_rd + 1'b1;
            p_we = 1'b1; p_wa = cnt_ff[NW-1:0]; p_wd = PW'(b_rd);
            r_we = 1'b1; r_wa = b_rd[NW-1:0]; r_wd = cnt_ff[NW-1:0];
         end
         S_SH_RD: begin
            b_ra = EW'(cnt_ff - 1'b1);
            if (cnt_ff == '0) begin
               b_we = 1'b1; b_wa = '0; b_wd = '0;
            end
         end
         S_SH_W: begin
            b_we = 1'b1; b_wa = cnt_ff[EW-1:0]; b_wd = b_rd;
         end
         S_PE_RD: r_ra = cnt_ff[NW-1:0];
         S_PE_V: begin
            d_ra = r_rd; o_ra = NCW'(r_rd);
         end
         S_PE_V2: o_ra = NCW'(v_ff) + 1'b1;
         S_PE_K:  t_ra = k_ff[TAW-1:0];
         S_PE_U:  d_ra = t_rd;
         S_PE_DU: begin
            p_ra = u_ff; b_ra = d_rd;
         end
         S_PE_PW: r_ra = b_rd[NW-1:0];
         S_PE_W: begin
            if (r_rd != u_ff) begin
               p_we = 1'b1; p_wa = u_ff; p_wd = PW'(pw_ff);
               r_we = 1'b1; r_wa = pw_ff; r_wd = u_ff;
            end
         end
         S_PE_SW2: begin
            p_we = 1'b1; p_wa = w_ff; p_wd = PW'(pu_ff);
            r_we = 1'b1; r_wa = pu_ff; r_wd = w_ff;
         end
         S_PE_FIN: begin
            b_we = 1'b1; b_wa = du_ff; b_wd = NCW'(pw_ff) + 1'b1;
            d_we = 1'b1; d_wa = u_ff; d_wd = du_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         edges_ff      <= '0;
         valid_ff      <= 1'b0;
         ncount_ff     <= NCOUNT_W'(1);
         rsp_strobe_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_we) begin
            ncount_ff <= csr_wdata;
            valid_ff  <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  node_a_ff      <= req_node_a;
                  rsp_node_id_ff <= req_node_a;
                  rsp_core_ff    <= '0;
                  rsp_status_ff  <= ST_OK;
                  case (req_opcode)
                     OP_CLEAR: begin
                        edges_ff      <= '0;
                        valid_ff      <= 1'b0;
                        rsp_strobe_ff <= 1'b1;
                     end
                     OP_ADD: begin
                        rsp_strobe_ff <= 1'b1;
                        if (a_bad || b_bad || req_node_a == req_node_b) begin
                           rsp_status_ff <= ST_BAD;
                        end else if (edges_ff == EW'(MAX_EDGES)) begin
                           rsp_status_ff <= ST_FULL;
                        end else begin
                           edges_ff <= edges_ff + 1'b1;
                           valid_ff <= 1'b0;
                        end
                     end
                     OP_COMPUTE: begin
                        cnt_ff   <= '0;
                        acc_ff   <= '0;
                        maxd_ff  <= '0;
                        state_ff <= S_CLR;
                     end
                     default: begin
                        if (!valid_ff) begin
                           rsp_status_ff <= ST_NOTCOMP;
                           rsp_strobe_ff <= 1'b1;
                        end else if (a_bad) begin
                           rsp_status_ff <= ST_BAD;
                           rsp_strobe_ff <= 1'b1;
                        end else begin
                           state_ff <= S_RD_W;
                        end
                     end
                  endcase
               end
            end
            S_RD_W: begin
               rsp_core_ff   <= CORE_W'(d_rd);
               rsp_strobe_ff <= 1'b1;
               state_ff      <= S_IDLE;
            end
            S_CLR: begin
               if (cnt_ff == CW'(act_n) - 1'b1) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DG_RD;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_DG_RD: begin
               if (cnt_ff == CW'(edges_ff)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_OFF_RD;
               end else begin
                  state_ff <= S_DG_A;
               end
            end
            S_DG_A: begin
               ea_ff <= e_a;
               eb_ff <= e_b;
               if (e_ok) begin
                  state_ff <= S_DG_AW;
               end else begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_DG_RD;
               end
            end
            S_DG_AW: state_ff <= S_DG_BW;
            S_DG_BW: begin
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= S_DG_RD;
            end
            S_OFF_RD: begin
               if (cnt_ff == CW'(act_n)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_ADJ_RD;
               end else begin
                  state_ff <= S_OFF_W;
               end
            end
            S_OFF_W: begin
               acc_ff <= acc_ff + OW'(d_rd);
               if (d_rd > maxd_ff) begin
                  maxd_ff <= d_rd;
               end
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= S_OFF_RD;
            end
            S_ADJ_RD: begin
               if (cnt_ff == CW'(edges_ff)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_BCLR;
               end else begin
                  state_ff <= S_ADJ_A;
               end
            end
            S_ADJ_A: begin
               ea_ff <= e_a;
               eb_ff <= e_b;
               if (e_ok) begin
                  state_ff <= S_ADJ_AW;
               end else begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_ADJ_RD;
               end
            end
            S_ADJ_AW: state_ff <= S_ADJ_BW;
            S_ADJ_BW: begin
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= S_ADJ_RD;
            end
            S_BCLR: begin
               if (cnt_ff == CW'(maxd_ff)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_BCNT_RD;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_BCNT_RD: begin
               if (cnt_ff == CW'(act_n)) begin
                  cnt_ff   <= '0;
                  start_ff <= '0;
                  state_ff <= S_BPRE_RD;
               end else begin
                  state_ff <= S_BCNT_B;
               end
            end
            S_BCNT_B: begin
               du_ff    <= d_rd;
               state_ff <= S_BCNT_W;
            end
            S_BCNT_W: begin
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= S_BCNT_RD;
            end
            S_BPRE_RD: state_ff <= S_BPRE_W;
            S_BPRE_W: begin
               start_ff <= start_ff + b_rd;
               if (cnt_ff == CW'(maxd_ff)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_PL_RD;
               end else begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_BPRE_RD;
               end
            end
            S_PL_RD: begin
               if (cnt_ff == CW'(act_n)) begin
                  cnt_ff   <= CW'(maxd_ff);
                  state_ff <= S_SH_RD;
               end else begin
                  state_ff <= S_PL_B;
               end
            end
            S_PL_B: begin
               du_ff    <= d_rd;
               state_ff <= S_PL_W;
            end
            S_PL_W: begin
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= S_PL_RD;
            end
            S_SH_RD: begin
               if (cnt_ff == '0) begin
                  state_ff <= S_PE_RD;
               end else begin
                  state_ff <= S_SH_W;
               end
            end
            S_SH_W: begin
               cnt_ff   <= cnt_ff - 1'b1;
               state_ff <= S_SH_RD;
            end
            S_PE_RD: begin
               if (cnt_ff == CW'(act_n)) begin
                  valid_ff       <= 1'b1;
                  rsp_strobe_ff  <= 1'b1;
                  rsp_node_id_ff <= node_a_ff;
                  rsp_core_ff    <= '0;
                  rsp_status_ff  <= ST_OK;
                  state_ff       <= S_IDLE;
               end else begin
                  state_ff <= S_PE_V;
               end
            end
            S_PE_V: begin
               v_ff     <= r_rd;
               state_ff <= S_PE_V2;
            end
            S_PE_V2: begin
               dv_ff    <= d_rd;
               k_ff     <= o_rd;
               state_ff <= S_PE_V3;
            end
            S_PE_V3: begin
               kend_ff  <= o_rd;
               state_ff <= S_PE_K;
            end
            S_PE_K: begin
               if (k_ff == kend_ff) begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_PE_RD;
               end else begin
                  state_ff <= S_PE_U;
               end
            end
            S_PE_U: begin
               u_ff     <= t_rd;
               state_ff <= S_PE_DU;
            end
            S_PE_DU: begin
               du_ff <= d_rd;
               if (d_rd > dv_ff) begin
                  state_ff <= S_PE_PW;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_PE_K;
               end
            end
            S_PE_PW: begin
               pu_ff    <= p_rd[NW-1:0];
               pw_ff    <= b_rd[NW-1:0];
               state_ff <= S_PE_W;
            end
            S_PE_W: begin
               w_ff <= r_rd;
               if (r_rd != u_ff) begin
                  state_ff <= S_PE_SW2;
               end else begin
                  state_ff <= S_PE_FIN;
               end
            end
            S_PE_SW2: state_ff <= S_PE_FIN;
            S_PE_FIN: begin
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_PE_K;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   kcd_ram #(.WIDTH(2*NW), .DEPTH(MAX_EDGES)) u_edge (
      .clock(clock), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
   kcd_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg (
      .clock(clock), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
   kcd_ram #(.WIDTH(OW), .DEPTH(MAX_NODES + 1)) u_offs (
      .clock(clock), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
   kcd_ram #(.WIDTH(NW), .DEPTH(2 * MAX_EDGES)) u_tgt (
      .clock(clock), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
   kcd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_order (
      .clock(clock), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
   kcd_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_pos (
      .clock(clock), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
   kcd_ram #(.WIDTH(NCW), .DEPTH(MAX_EDGES + 1)) u_bin (
      .clock(clock), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
endmodule
`default_nettype wire

>>> rtl/kcd_ram.sv
// kcd_ram: generic single-write, single-read synchronous RAM
// registered read data; no dependencies
`default_nettype none
module kcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> rtl/kcd_checker.sv
// kcd_checker: port-level assertions for graph_kcore_decomposition
// depends on kcd_pkg; attached to the top level by the bind below
`default_nettype none
module kcd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic [kcd_pkg::OP_W-1:0]      req_opcode,
   input wire logic [kcd_pkg::ID_W-1:0]      req_node_a,
   input wire logic [kcd_pkg::ID_W-1:0]      req_node_b,
   input wire logic                          rsp_strobe,
   input wire logic [kcd_pkg::CORE_W-1:0]    rsp_core_number,
   input wire logic [kcd_pkg::STAT_W-1:0]    rsp_status
);
   import kcd_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result beat right after reset");

   a_err_no_core: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_core_number == '0)
      else $error("nonzero core on failed beat");

   a_clear_ok: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == OP_CLEAR |=> rsp_strobe && rsp_status == ST_OK)
      else $error("clear did not answer ok");

   a_self_loop: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == OP_ADD && req_node_a == req_node_b
      |=> rsp_strobe && rsp_status == ST_BAD)
      else $error("self-loop not rejected");
endmodule

bind graph_kcore_decomposition kcd_checker u_kcd_checker (.*);
`default_nettype wire

>>> tb/sv/kcd_checker.sv
// kcd_scoreboard: watches the command, result and csr ports of graph_kcore_decomposition
// keeps its own copy of the graph, predicts each result beat and compares; needs kcd_pkg
`default_nettype none
module kcd_scoreboard
   import kcd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic [OP_W-1:0]      req_opcode,
   input  wire logic [ID_W-1:0]      req_node_a,
   input  wire logic [ID_W-1:0]      req_node_b,
   input  wire logic                 rsp_strobe,
   input  wire logic [ID_W-1:0]      rsp_node_id,
   input  wire logic [CORE_W-1:0]    rsp_core_number,
   input  wire logic [STAT_W-1:0]    rsp_status,
   input  wire logic                 csr_we,
   input  wire logic [NCOUNT_W-1:0]  csr_wdata,
   output int                        fails,
   output int                        pending
);
   localparam int NMAX = DEF_MAX_NODES;
   localparam int EMAX = DEF_MAX_EDGES;

   typedef struct packed {
      logic [ID_W-1:0]   node_id;
      logic [CORE_W-1:0] core_number;
      logic [STAT_W-1:0] status;
   } core_rsp_type;

   core_rsp_type rsp_fifo[$];

   logic [NCOUNT_W-1:0] g_count;
   logic [ID_W-1:0]     g_ea[EMAX];
   logic [ID_W-1:0]     g_eb[EMAX];
   int                  g_edges;
   int                  g_core[NMAX];
   bit                  g_valid;
   int                  g_off[NMAX+1];
   int                  g_tgt[2*EMAX];
   int                  g_ord[NMAX];
   int                  g_pos[NMAX];
   int                  g_bin[2*EMAX+1];

   assign pending = rsp_fifo.size();

   function automatic int nodes_in_use();
      if (g_count == 0) return 1;
      if (g_count > NMAX) return NMAX;
      return int'(g_count);
   endfunction

   // bin-sorted peeling over the stored edges
   function automatic void peel_cores();
      int n, maxd, a, b, s, c, v, u, du, pu, pw, w;
      n = nodes_in_use();
      maxd = 0;
      for (int i = 0; i < NMAX; i++) g_core[i] = 0;
      for (int e = 0; e < g_edges; e++) begin
         a = g_ea[e]; b = g_eb[e];
         if (a < n && b < n && a != b) begin
            g_core[a]++; g_core[b]++;
         end
      end
      g_off[0] = 0;
      for (int i = 0; i < n; i++) begin
         g_off[i+1] = g_off[i] + g_core[i];
         g_pos[i] = g_off[i];
         if (g_core[i] > maxd) maxd = g_core[i];
      end
      for (int e = 0; e < g_edges; e++) begin
         a = g_ea[e]; b = g_eb[e];
         if (a < n && b < n && a != b) begin
            g_tgt[g_pos[a]] = b; g_pos[a]++;
            g_tgt[g_pos[b]] = a; g_pos[b]++;
         end
      end
      for (int d = 0; d <= maxd; d++) g_bin[d] = 0;
      for (int i = 0; i < n; i++) g_bin[g_core[i]]++;
      s = 0;
      for (int d = 0; d <= maxd; d++) begin
         c = g_bin[d]; g_bin[d] = s; s += c;
      end
      for (int i = 0; i < n; i++) begin
         g_pos[i] = g_bin[g_core[i]];
         g_ord[g_pos[i]] = i;
         g_bin[g_core[i]]++;
      end
      for (int d = maxd; d > 0; d--) g_bin[d] = g_bin[d-1];
      g_bin[0] = 0;
      for (int i = 0; i < n; i++) begin
         v = g_ord[i];
         for (int k = g_off[v]; k < g_off[v+1]; k++) begin
            u = g_tgt[k];
            if (g_core[u] > g_core[v]) begin
               du = g_core[u]; pu = g_pos[u]; pw = g_bin[du]; w = g_ord[pw];
               if (u != w) begin
                  g_pos[u] = pw; g_ord[pw] = u;
                  g_pos[w] = pu; g_ord[pu] = w;
               end
               g_bin[du]++;
               g_core[u] = du - 1;
            end
         end
      end
      g_valid = 1;
   endfunction

   function automatic core_rsp_type predict_beat(logic [OP_W-1:0] op, logic [ID_W-1:0] a,
                                                 logic [ID_W-1:0] b);
      core_rsp_type r;
      int n;
      n = nodes_in_use();
      r.node_id = a;
      r.core_number = '0;
      r.status = ST_OK;
      case (op)
         OP_CLEAR: begin
            g_edges = 0;
            g_valid = 0;
         end
         OP_ADD: begin
            if (a >= n || b >= n || a == b) r.status = ST_BAD;
            else if (g_edges >= EMAX) r.status = ST_FULL;
            else begin
               g_ea[g_edges] = a; g_eb[g_edges] = b;
               g_edges++;
               g_valid = 0;
            end
         end
         OP_COMPUTE: peel_cores();
         default: begin
            if (!g_valid) r.status = ST_NOTCOMP;
            else if (a >= n) r.status = ST_BAD;
            else r.core_number = CORE_W'(g_core[a]);
         end
      endcase
      return r;
   endfunction

   task automatic report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fails++;
   endtask

   initial fails = 0;

   always @(posedge clock) begin
      core_rsp_type want;
      if (reset) begin
         g_count = 1;
         g_edges = 0;
         g_valid = 0;
         for (int i = 0; i < NMAX; i++) g_core[i] = 0;
         rsp_fifo.delete();
      end else begin
         if (rsp_strobe) begin
            if (rsp_fifo.size() == 0) begin
               report($sformatf("unexpected beat node %0d status %0d", rsp_node_id,
                                rsp_status));
            end else begin
               want = rsp_fifo.pop_front();
               if (rsp_node_id !== want.node_id)
                  report($sformatf("node_id %0d, want %0d", rsp_node_id, want.node_id));
               if (rsp_core_number !== want.core_number)
                  report($sformatf("core_number %0d, want %0d for node %0d",
                                   rsp_core_number, want.core_number, want.node_id));
               if (rsp_status !== want.status)
                  report($sformatf("status %0d, want %0d for node %0d", rsp_status,
                                   want.status, want.node_id));
            end
         end
         if (csr_we) begin
            g_count = csr_wdata;
            g_valid = 0;
         end
         if (start && !busy)
            rsp_fifo = {rsp_fifo, predict_beat(req_opcode, req_node_a, req_node_b)};
      end
   end
endmodule
`default_nettype wire

>>> tb/sv/tb_graph_kcore_decomposition.sv
// tb_graph_kcore_decomposition: stimulus and verdict for graph_kcore_decomposition
// depends on kcd_pkg, the block itself and kcd_scoreboard, which compares every result beat
`default_nettype none
module tb_graph_kcore_decomposition;
   import kcd_pkg::*;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_opcode;
   logic [ID_W-1:0]     req_node_a;
   logic [ID_W-1:0]     req_node_b;
   logic                rsp_strobe;
   logic [ID_W-1:0]     rsp_node_id;
   logic [CORE_W-1:0]   rsp_core_number;
   logic [STAT_W-1:0]   rsp_status;
   logic                csr_we;
   logic [NCOUNT_W-1:0] csr_wdata;
   int                  fails;
   int                  pending;

   int  beats_sent = 0;
   int  computes = 0;
   int  phases = 0;
   bit  quiet = 0;
   int  live_n = 1;

   graph_kcore_decomposition u_dut (
      .clock, .reset, .start, .busy, .req_opcode, .req_node_a, .req_node_b,
      .rsp_strobe, .rsp_node_id, .rsp_core_number, .rsp_status, .csr_we, .csr_wdata
   );

   kcd_scoreboard u_chk (
      .clock, .reset, .start, .busy, .req_opcode, .req_node_a, .req_node_b,
      .rsp_strobe, .rsp_node_id, .rsp_core_number, .rsp_status, .csr_we, .csr_wdata,
      .fails, .pending
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("timeout");
      $display("tb_graph_kcore_decomposition failed");
      $finish;
   end

   task automatic send(logic [OP_W-1:0] op, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1;
      req_opcode <= op;
      req_node_a <= a;
      req_node_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
      if (op == OP_COMPUTE) computes++;
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(logic [NCOUNT_W-1:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      live_n = (v == 0) ? 1 : (v > DEF_MAX_NODES ? DEF_MAX_NODES : int'(v));
   endtask

   function automatic logic [ID_W-1:0] any_id();
      return ID_W'($urandom);
   endfunction

   // one build-compute-read round on the current node count
   task automatic graph_round();
      int ne, lim, a, b;
      logic [OP_W-1:0] op;
      send(OP_CLEAR, any_id(), any_id());
      lim = (live_n < 2) ? 0 : ((live_n * 3 < 50) ? live_n * 3 : 50);
      ne = $urandom_range(0, lim);
      for (int i = 0; i < ne; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: op = OP_ADD;
               1: op = OP_COMPUTE;
               default: op = OP_READ;
            endcase
            send(op, any_id(), any_id());
         end else begin
            a = $urandom_range(0, live_n - 1);
            b = $urandom_range(0, live_n - 1);
            if (a == b) b = (a + 1) % live_n;
            send(OP_ADD, ID_W'(a), ID_W'(b));
         end
      end
      send(OP_COMPUTE, any_id(), any_id());
      for (int i = 0; i < $urandom_range(2, 12); i++) begin
         if ($urandom_range(0, 7) == 0) send(OP_READ, any_id(), any_id());
         else send(OP_READ, ID_W'($urandom_range(0, live_n - 1)), any_id());
      end
      if ($urandom_range(0, 3) == 0) begin
         send(OP_ADD, any_id(), any_id());
         send(OP_READ, ID_W'($urandom_range(0, live_n - 1)), any_id());
      end
   endtask

   initial begin
      int pick;
      reset = 1;
      start = 0;
      req_opcode = OP_CLEAR;
      req_node_a = '0;
      req_node_b = '0;
      csr_we = 0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      send(OP_READ, 0, 0);
      send(OP_ADD, 0, 0);
      send(OP_COMPUTE, 0, 0);
      send(OP_READ, 0, 0);
      send(OP_READ, 1023, 1023);
      write_count(5);
      send(OP_READ, 0, 0);
      send(OP_ADD, 0, 1);
      send(OP_ADD, 1, 2);
      send(OP_ADD, 2, 0);
      send(OP_ADD, 0, 1);
      send(OP_ADD, 3, 4);
      send(OP_ADD, 4, 4);
      send(OP_ADD, 0, 1023);
      send(OP_COMPUTE, 0, 0);
      for (int i = 0; i < 6; i++) send(OP_READ, ID_W'(i), 0);
      send(OP_ADD, 1, 3);
      send(OP_READ, 0, 0);
      send(OP_COMPUTE, 0, 0);
      send(OP_ADD, 9, 9);
      send(OP_READ, 1, 0);
      send(OP_CLEAR, 0, 0);
      send(OP_READ, 1, 0);

      // node count shrinks under stored edges
      write_count(4);
      send(OP_CLEAR, 0, 0);
      quiet = 1;
      for (int i = 0; i < 12; i++) send(OP_ADD, ID_W'(i % 4), ID_W'((i + 1 + i / 4) % 4 == i % 4 ?
                                                   (i + 2) % 4 : (i + 1 + i / 4) % 4));
      send(OP_ADD, 0, 1);
      send(OP_ADD, 2, 2);
      quiet = 0;
      send(OP_COMPUTE, 0, 0);
      for (int i = 0; i < 4; i++) send(OP_READ, ID_W'(i), 0);
      write_count(2);
      send(OP_COMPUTE, 0, 0);
      send(OP_READ, 0, 0);
      send(OP_READ, 1, 0);
      send(OP_CLEAR, 0, 0);

      // random phases
      while (beats_sent < 1620) begin
         case (phases)
            0: pick = 1024;
            1: pick = 2047;
            2: pick = 0;
            3: pick = 1;
            4: pick = 2;
            default: pick = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                                       : $urandom_range(3, 40);
         endcase
         write_count(NCOUNT_W'(pick));
         phases++;
         quiet = (beats_sent > 1400);
         repeat ($urandom_range(2, 5)) graph_round();
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d command beats in %0d node-count phases, %0d core computes",
               beats_sent, phases, computes);
      if (fails == 0 && pending == 0) begin
         $display("tb_graph_kcore_decomposition passed");
      end else begin
         $display("tb_graph_kcore_decomposition failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> graph_kcore_decomposition.f
rtl/kcd_pkg.sv
rtl/kcd_ram.sv
rtl/graph_kcore_decomposition.sv
rtl/kcd_checker.sv
tb/sv/kcd_checker.sv
tb/sv/tb_graph_kcore_decomposition.sv
